### design/sdpc_pkg.sv
`default_nettype none
package sdpc_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W     = 2;
  localparam int NOW_W    = 32;
  localparam int AGREE_W  = 8;
  localparam int PRESS_W  = 16;
  localparam int MS_W     = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_ON     = 2'd1,
    CMD_OFF    = 2'd2,
    CMD_TOGGLE = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_FOLLOW   = 3'd0;
  localparam logic [2:0] REG_STABLE   = 3'd1;
  localparam logic [2:0] REG_HOLDOFF  = 3'd2;
  localparam logic [2:0] REG_WINDOW   = 3'd3;
  localparam logic [2:0] REG_THRESH   = 3'd4;

  localparam logic               RST_FOLLOW  = 1'b0;
  localparam logic [AGREE_W-1:0] RST_STABLE  = 8'd5;
  localparam logic [MS_W-1:0]    RST_HOLDOFF = 16'd100;
  localparam logic [MS_W-1:0]    RST_WINDOW  = 16'd10000;
  localparam logic [7:0]         RST_THRESH  = 8'd7;

  typedef struct packed {
    logic               armed;
    logic [NOW_W-1:0]   holdoff_until;
    logic [NOW_W-1:0]   window_start;
    logic [PRESS_W-1:0] presses;
    logic [AGREE_W-1:0] agree;
    logic               pressed;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

endpackage
`default_nettype wire

### design/switch_debounce_press_counter.sv
`default_nettype none
// Debounced switch channels with relay commands and multi-press detection.
// Input channel (in_*): one pin sample per item, tagged with its channel and a
// millisecond time stamp. Output channel (out_*): exactly one result item per
// input item, in order, with the relay command, the channel's press count and
// the reset request flag. Configuration goes through the APB-style cfg_* port;
// write it only while no item is in flight.
// The input item is registered in the read stage and its result in the output
// register when the update stage advances. Throughput: one item per cycle
// unless the update stage stalls. Per-channel state sits in a small RAM with a
// registered read; the update stage writes back on each advance, and the last
// write is forwarded to a later item of the same channel.
// Reset: configuration returns to its defaults and every channel reads as zero
// state (per-entry valid bits), so no clearing pass is needed.
// Stall: a full output register that is not taken holds the update stage and
// drops in_tready; one item waits in the update stage, nothing is lost.
module switch_debounce_press_counter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // channel[1:0], pin_level[2], relay_locked[3], now_ms[35:4]
  input  logic [sdpc_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // channel_out[1:0], relay_command[3:2], press_count[19:4], reset_request[20]
  output logic [sdpc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [sdpc_pkg::CFG_AW-1:0]           cfg_paddr,
  input  logic [sdpc_pkg::CFG_DW-1:0]           cfg_pwdata,
  output logic [sdpc_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                  cfg_pready
);
  import sdpc_pkg::*;

  // configuration
  logic               follow_r;
  logic [AGREE_W-1:0] stable_r;
  logic [MS_W-1:0]    holdoff_r;
  logic [MS_W-1:0]    window_r;
  logic [7:0]         thresh_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_r  <= RST_FOLLOW;
      stable_r  <= RST_STABLE;
      holdoff_r <= RST_HOLDOFF;
      window_r  <= RST_WINDOW;
      thresh_r  <= RST_THRESH;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FOLLOW:  follow_r  <= cfg_pwdata[0];
        REG_STABLE:  stable_r  <= cfg_pwdata[AGREE_W-1:0];
        REG_HOLDOFF: holdoff_r <= cfg_pwdata[MS_W-1:0];
        REG_WINDOW:  window_r  <= cfg_pwdata[MS_W-1:0];
        REG_THRESH:  thresh_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FOLLOW:  cfg_prdata = {{(CFG_DW-1){1'b0}}, follow_r};
      REG_STABLE:  cfg_prdata = {{(CFG_DW-AGREE_W){1'b0}}, stable_r};
      REG_HOLDOFF: cfg_prdata = {{(CFG_DW-MS_W){1'b0}}, holdoff_r};
      REG_WINDOW:  cfg_prdata = {{(CFG_DW-MS_W){1'b0}}, window_r};
      REG_THRESH:  cfg_prdata = {{(CFG_DW-8){1'b0}}, thresh_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // input and read stage
  logic             in_acc;
  logic [CH_AW-1:0] in_addr;
  logic             s1_valid_r;
  logic [CH_W-1:0]  s1_ch_r;
  logic             s1_pin_r;
  logic             s1_lock_r;
  logic [NOW_W-1:0] s1_now_r;
  logic             s1_go;
  logic             s1_adv;
  logic             out_valid_r;

  logic [CHANNELS-1:0] vld_r;
  logic                rd_vld_r;
  logic                fwd_valid_r;
  logic [CH_AW-1:0]    fwd_addr_r;
  chan_state_t         fwd_data_r;
  logic [STATE_W-1:0]  ram_rdata;
  logic                ram_we;
  logic [CH_AW-1:0]    s1_addr;

  assign s1_go     = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s1_go;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign in_addr   = CH_AW'(in_tdata[1:0]);
  assign s1_addr   = CH_AW'(s1_ch_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r   <= in_tdata[1:0];
      s1_pin_r  <= in_tdata[2];
      s1_lock_r <= in_tdata[3];
      s1_now_r  <= in_tdata[35:4];
      rd_vld_r  <= vld_r[in_addr];
    end
  end

  // update stage
  logic               ch_ok;
  chan_state_t        cur;
  chan_state_t        st_nxt;
  logic               want;
  logic [NOW_W-1:0]   remain;
  logic               ignore;
  logic [AGREE_W-1:0] agree_inc;
  logic               accept;
  logic               win_clear;
  logic [PRESS_W-1:0] p_base;
  logic [PRESS_W-1:0] p_inc;
  logic [NOW_W-1:0]   ws_base;
  cmd_t               cmd;
  logic               req;

  assign ch_ok = (32'(s1_ch_r) < CHANNELS);
  assign want  = !s1_pin_r;

  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr) begin
      cur = fwd_data_r;
    end else if (rd_vld_r) begin
      cur = chan_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  assign remain    = cur.holdoff_until - s1_now_r;
  assign ignore    = cur.armed && (remain != '0) && (remain <= NOW_W'(holdoff_r));
  assign agree_inc = (cur.agree == '1) ? cur.agree : cur.agree + 1'b1;
  assign accept    = !ignore && (want != cur.pressed) && (agree_inc >= stable_r);
  assign win_clear = want && (cur.presses != '0) &&
                     ((s1_now_r - cur.window_start) > NOW_W'(window_r));
  assign p_base    = win_clear ? '0 : cur.presses;
  assign p_inc     = (p_base == '1) ? p_base : p_base + 1'b1;
  assign ws_base   = (want && (cur.presses == '0 || win_clear)) ? s1_now_r
                                                                : cur.window_start;

  always_comb begin
    st_nxt       = cur;
    st_nxt.armed = cur.armed && ignore;
    cmd          = CMD_NONE;
    if (!ignore) begin
      if (want == cur.pressed) begin
        st_nxt.agree = '0;
      end else begin
        st_nxt.agree = agree_inc;
      end
    end
    if (accept) begin
      st_nxt.window_start = ws_base;
      st_nxt.presses      = p_base;
      if (want) begin
        if (follow_r) begin
          st_nxt.presses = p_inc;
          cmd            = CMD_ON;
        end
      end else begin
        if (follow_r) begin
          cmd = CMD_OFF;
        end else begin
          st_nxt.presses = p_inc;
          cmd            = CMD_TOGGLE;
        end
      end
      if (s1_lock_r) begin
        cmd = CMD_NONE;
      end
      st_nxt.pressed       = want;
      st_nxt.agree         = '0;
      st_nxt.holdoff_until = s1_now_r + NOW_W'(holdoff_r);
      st_nxt.armed         = 1'b1;
    end
  end

  assign req = (st_nxt.presses >= PRESS_W'(thresh_r)) &&
               ((s1_now_r - st_nxt.window_start) <= NOW_W'(window_r));

  assign ram_we = s1_adv && ch_ok;

  sdpc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (st_nxt),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      fwd_valid_r <= 1'b0;
    end else if (ram_we) begin
      vld_r[s1_addr] <= 1'b1;
      fwd_valid_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= st_nxt;
    end
  end

  // output register
  logic               out_valid_nxt;
  logic [CH_W-1:0]    out_ch_r;
  cmd_t               out_cmd_r;
  logic [PRESS_W-1:0] out_press_r;
  logic               out_req_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r    <= s1_ch_r;
      out_cmd_r   <= ch_ok ? cmd : CMD_NONE;
      out_press_r <= ch_ok ? st_nxt.presses : '0;
      out_req_r   <= ch_ok && req;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_req_r, out_press_r, out_cmd_r, out_ch_r};

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_ch_r) && $stable(s1_now_r))
    else $error("update stage lost its item while stalled");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> fwd_valid_r && fwd_addr_r == $past(s1_addr))
    else $error("forwarding register missed a write");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> vld_r[$past(s1_addr)])
    else $error("written entry not marked valid");

  a_toggle_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r == CMD_TOGGLE |-> !follow_r)
    else $error("toggle command in follow mode");

  a_req_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_req_r |-> out_press_r >= PRESS_W'(thresh_r))
    else $error("reset request below threshold");

endmodule
`default_nettype wire

### design/sdpc_ram.sv
`default_nettype none
module sdpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
